// ===== src/apd_pkg.sv =====
package apd_pkg;

    // Default geometry
    localparam int SLOTS_DEF    = 8;
    localparam int RING_DEF     = 8;
    localparam int DISPATCH_DEF = 4;

    // Function codes
    localparam logic [2:0] FN_REG   = 3'd0;
    localparam logic [2:0] FN_EVT   = 3'd1;
    localparam logic [2:0] FN_STATE = 3'd2;
    localparam logic [2:0] FN_PROC  = 3'd3;
    localparam logic [2:0] FN_DONE  = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOMATCH = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_DISP    = 3'd3;
    localparam logic [2:0] ST_IDLE    = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_LEVEL = 2'd0;
    localparam logic [1:0] CFG_EVENT = 2'd1;
    localparam logic [1:0] CFG_STATE = 2'd2;

    typedef struct packed {
        logic [7:0] handler;
        logic [7:0] kind;
        logic [7:0] state;
        logic [7:0] level;
        logic [7:0] evt;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_REG, S_SCAN, S_APP_WR, S_DISP, S_DONE_RD, S_DONE_WR,
        S_CMPCT, S_COUNT, S_PEND_CHK, S_KEY_RD, S_KEY_WR, S_SORT_START, S_SORT,
        S_AGE, S_LOAD_RD, S_LOAD_WR, S_LOAD_END, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_REG, OP_SCAN, OP_APP_WR, OP_DISP, OP_DONE_RD,
        OP_DONE_WR, OP_CMPCT, OP_COUNT, OP_KEY_RD, OP_KEY_WR, OP_SORT, OP_AGE,
        OP_LOAD_RD, OP_LOAD_WR, OP_LOAD_END
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   out_valid;
    } t_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic       slot_ok;
        logic       disp_avail;
        logic       done_ok;
        logic       app_found;
    } t_dp_stat;

endpackage

// ===== src/apd_datapath.sv =====
module apd_datapath
    import apd_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int RING_DEPTH = RING_DEF,
    parameter int DISPATCH   = DISPATCH_DEF,
    localparam int IW = $clog2(SLOTS),
    localparam int NW = $clog2(SLOTS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    input  logic [2:0]       i_func,
    input  logic [2:0]       i_slot_index,
    input  logic [7:0]       i_task_kind,
    input  logic [7:0]       i_handler_id,
    input  logic [7:0]       i_new_level,
    input  logic [7:0]       i_new_event,
    input  logic [7:0]       i_new_state,
    input  t_cmd             i_cmd,
    input  logic [IW-1:0]    i_r,
    input  logic [IW-1:0]    i_c,
    output t_dp_stat         o_stat,
    output logic [NW-1:0]    o_pend,
    output logic [2:0]       o_status,
    output t_entry           o_run,
    output logic [3:0]       o_pending_slots
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int NE = SLOTS * RING_DEPTH;
    localparam int AW = $clog2(NE);
    localparam int LW = (DISPATCH > 1) ? $clog2(DISPATCH) : 1;
    localparam int DW = $clog2(DISPATCH + 1);

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        ring_next = (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
        ring_prev = (p == '0) ? PW'(RING_DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic logic [AW-1:0] ent_addr(input logic [IW-1:0] s,
                                               input logic [PW-1:0] w);
        ent_addr = AW'(s) * AW'(RING_DEPTH) + AW'(w);
    endfunction

    // Configuration and latched beat
    logic [7:0] r_cfg_level, r_cfg_event, r_cfg_state;
    logic [2:0] r_func, r_slot;
    logic [7:0] r_kind, r_hid, r_nlevel, r_nevent, r_nstate;

    // Entry store and per-slot bookkeeping
    t_entry            r_mem [NE];
    logic [NE-1:0]     r_valid;
    t_entry            r_rd;
    logic              r_rd_vld;
    logic [7:0]        r_kind0 [SLOTS];
    logic [7:0]        r_age   [SLOTS];
    logic [PW-1:0]     r_rptr  [SLOTS];
    logic [PW-1:0]     r_wptr  [SLOTS];
    logic [CW-1:0]     r_cnt   [SLOTS];
    logic [SLOTS-1:0]  r_full;
    logic [IW-1:0]     r_order [SLOTS];
    logic [8:0]        r_key   [SLOTS];
    t_entry            r_dlist [DISPATCH];
    logic [DW-1:0]     r_dread, r_dend;
    logic [NW-1:0]     r_pend;
    logic [IW-1:0]     r_tk_p;
    logic [PW-1:0]     r_tk_w;
    logic              r_found;
    logic [2:0]        r_res_status;
    t_entry            r_res_run;
    logic [3:0]        r_res_pend;

    logic              slot_ok;
    logic [IW-1:0]     reg_p;
    logic              tk_found, tk_saw;
    logic [IW-1:0]     tk_p;
    logic [SLOTS-1:0]  full_set;
    logic [IW-1:0]     done_p, kp, rp, cp;
    logic [NW-1:0]     pend_cnt;
    logic [DW-1:0]     load_size;
    t_entry            rd_eff, app_ent, wr_ent;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic              mem_we;

    assign slot_ok = (32'(r_slot) < SLOTS);
    assign reg_p   = r_order[IW'(r_slot)];
    assign done_p  = r_order[IW'(r_dread - 1'b1)];
    assign kp      = r_order[i_r];
    assign rp      = r_order[i_r];
    assign cp      = r_order[i_c];
    assign rd_eff  = r_rd_vld ? r_rd : '0;
    assign load_size = (32'(r_pend) > DISPATCH) ? DW'(DISPATCH) : DW'(r_pend);

    // First matching slot with room, in logical order; full matches before it
    always_comb begin
        logic [IW-1:0] sp;
        tk_found = 1'b0;
        tk_saw   = 1'b0;
        tk_p     = '0;
        full_set = '0;
        for (int k = 0; k < SLOTS; k++) begin
            sp = r_order[k];
            if (!tk_found && r_kind0[sp] == r_kind) begin
                if (r_cnt[sp] < CW'(RING_DEPTH)) begin
                    tk_found = 1'b1;
                    tk_p     = sp;
                end else begin
                    full_set[sp] = 1'b1;
                    tk_saw       = 1'b1;
                end
            end
        end
    end

    // Non-empty slot count
    always_comb begin
        pend_cnt = '0;
        for (int s = 0; s < SLOTS; s++) begin
            if (r_cnt[s] != '0) pend_cnt = pend_cnt + 1'b1;
        end
    end

    // Appended entry
    always_comb begin
        if (r_func == FN_STATE) begin
            app_ent = '{handler: r_hid, kind: r_kind, state: r_nstate,
                        level: r_cfg_level, evt: r_cfg_event};
        end else begin
            app_ent = '{handler: rd_eff.handler, kind: r_kind, state: rd_eff.state,
                        level: r_nlevel, evt: r_nevent};
        end
    end

    // Store port selection
    always_comb begin
        rd_addr = '0;
        wr_addr = '0;
        wr_ent  = app_ent;
        mem_we  = 1'b0;
        unique case (i_cmd.op)
            OP_SCAN:    rd_addr = ent_addr(tk_p, ring_prev(r_wptr[tk_p]));
            OP_DONE_RD: rd_addr = ent_addr(done_p, r_rptr[done_p]);
            OP_KEY_RD,
            OP_LOAD_RD: rd_addr = ent_addr(kp, r_rptr[kp]);
            OP_REG: begin
                wr_addr = ent_addr(reg_p, '0);
                wr_ent  = '{handler: r_hid, kind: r_kind, state: r_cfg_state,
                            level: r_cfg_level, evt: r_cfg_event};
                mem_we  = slot_ok;
            end
            OP_APP_WR: begin
                wr_addr = ent_addr(r_tk_p, r_tk_w);
                mem_we  = 1'b1;
            end
            OP_DONE_WR: begin
                wr_addr = ent_addr(done_p, r_rptr[done_p]);
                wr_ent  = '{handler: rd_eff.handler, kind: rd_eff.kind,
                            state: rd_eff.state, level: 8'd0, evt: 8'd0};
                mem_we  = 1'b1;
            end
            default: ;
        endcase
    end

    // Entry store
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[wr_addr] <= wr_ent;
        r_rd <= r_mem[rd_addr];
    end

    // Control and bookkeeping registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_level  <= 8'd5;
            r_cfg_event  <= 8'd1;
            r_cfg_state  <= 8'd1;
            r_valid      <= '0;
            r_rd_vld     <= 1'b0;
            r_full       <= '0;
            r_dread      <= '0;
            r_dend       <= '0;
            r_pend       <= '0;
            r_found      <= 1'b0;
            r_res_status <= ST_IDLE;
            r_res_run    <= '0;
            r_res_pend   <= '0;
            for (int s = 0; s < SLOTS; s++) begin
                r_kind0[s] <= '0;
                r_age[s]   <= '0;
                r_rptr[s]  <= '0;
                r_wptr[s]  <= '0;
                r_cnt[s]   <= '0;
                r_order[s] <= IW'(s);
                r_key[s]   <= '0;
            end
            for (int d = 0; d < DISPATCH; d++) r_dlist[d] <= '0;
        end else begin
            r_rd_vld <= r_valid[rd_addr];
            if (mem_we) r_valid[wr_addr] <= 1'b1;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LEVEL: r_cfg_level <= i_cfg_data;
                    CFG_EVENT: r_cfg_event <= i_cfg_data;
                    CFG_STATE: r_cfg_state <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (i_cmd.op)
                OP_LATCH: begin
                    r_func       <= i_func;
                    r_slot       <= i_slot_index;
                    r_kind       <= i_task_kind;
                    r_hid        <= i_handler_id;
                    r_nlevel     <= i_new_level;
                    r_nevent     <= i_new_event;
                    r_nstate     <= i_new_state;
                    r_res_status <= ST_IDLE;
                    r_res_run    <= '0;
                    r_res_pend   <= '0;
                end
                OP_REG: begin
                    if (slot_ok) begin
                        r_wptr[reg_p]  <= ring_next(r_wptr[reg_p]);
                        if (r_cnt[reg_p] < CW'(RING_DEPTH))
                            r_cnt[reg_p] <= r_cnt[reg_p] + 1'b1;
                        r_kind0[reg_p] <= r_kind;
                        r_age[reg_p]   <= '0;
                        r_res_status   <= ST_OK;
                    end else begin
                        r_res_status   <= ST_NOMATCH;
                    end
                end
                OP_SCAN: begin
                    r_full       <= r_full | full_set;
                    r_found      <= tk_found;
                    r_tk_p       <= tk_p;
                    r_tk_w       <= r_wptr[tk_p];
                    r_res_status <= tk_saw ? ST_FULL : ST_NOMATCH;
                end
                OP_APP_WR: begin
                    r_age[r_tk_p]  <= '0;
                    r_wptr[r_tk_p] <= ring_next(r_tk_w);
                    r_cnt[r_tk_p]  <= r_cnt[r_tk_p] + 1'b1;
                    r_full[r_tk_p] <= 1'b0;
                    r_res_status   <= ST_OK;
                end
                OP_DISP: begin
                    r_res_run    <= r_dlist[r_dread[LW-1:0]];
                    r_dread      <= r_dread + 1'b1;
                    r_res_status <= ST_DISP;
                end
                OP_DONE_WR: begin
                    r_rptr[done_p] <= ring_next(r_rptr[done_p]);
                    if (r_cnt[done_p] != '0) r_cnt[done_p] <= r_cnt[done_p] - 1'b1;
                    r_res_status   <= ST_OK;
                end
                OP_CMPCT: begin
                    if (r_cnt[rp] == '0 && r_cnt[cp] != '0) begin
                        r_order[i_r] <= cp;
                        r_order[i_c] <= rp;
                    end
                end
                OP_COUNT: begin
                    r_pend     <= pend_cnt;
                    r_res_pend <= 4'(pend_cnt);
                end
                OP_KEY_WR: r_key[i_r] <= 9'(rd_eff.level) + 9'(r_age[kp]);
                OP_SORT: begin
                    if (r_key[i_r] < r_key[i_c]) begin
                        r_order[i_r] <= cp;
                        r_order[i_c] <= rp;
                        r_key[i_r]   <= r_key[i_c];
                        r_key[i_c]   <= r_key[i_r];
                    end
                end
                OP_AGE: begin
                    for (int s = 0; s < SLOTS; s++) begin
                        if (r_cnt[s] != '0 && r_age[s] != 8'hFF) r_age[s] <= r_age[s] + 1'b1;
                    end
                end
                OP_LOAD_WR: r_dlist[LW'(i_r)] <= rd_eff;
                OP_LOAD_END: begin
                    r_dread <= '0;
                    r_dend  <= load_size;
                end
                default: ;
            endcase
        end
    end

    assign o_stat = '{func: r_func, slot_ok: slot_ok, disp_avail: (r_dread < r_dend),
                      done_ok: (r_dread != '0), app_found: r_found};
    assign o_pend          = r_pend;
    assign o_status        = r_res_status;
    assign o_run           = r_res_run;
    assign o_pending_slots = r_res_pend;

endmodule

// ===== src/apd_ctrl.sv =====
module apd_ctrl
    import apd_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int DISPATCH = DISPATCH_DEF,
    localparam int IW = $clog2(SLOTS),
    localparam int NW = $clog2(SLOTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_out_stall,
    input  t_dp_stat      i_stat,
    input  logic [NW-1:0] i_pend,
    output t_cmd          o_cmd,
    output logic [IW-1:0] o_r,
    output logic [IW-1:0] o_c,
    output logic          o_in_stall
);

    t_state        r_state, n_state;
    logic [IW-1:0] r_r, n_r, r_c, n_c;
    logic [NW-1:0] size;

    assign size = (32'(i_pend) > DISPATCH) ? NW'(DISPATCH) : i_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_r     <= '0;
            r_c     <= '0;
        end else begin
            r_state <= n_state;
            r_r     <= n_r;
            r_c     <= n_c;
        end
    end

    // Next state and loop indexes
    always_comb begin
        n_state = r_state;
        n_r     = r_r;
        n_c     = r_c;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_DECODE;
            S_DECODE: begin
                unique case (i_stat.func) inside
                    FN_REG:          n_state = S_REG;
                    FN_EVT, FN_STATE: n_state = S_SCAN;
                    FN_PROC: begin
                        if (i_stat.disp_avail) begin
                            n_state = S_DISP;
                        end else begin
                            n_state = S_CMPCT;
                            n_r     = '0;
                            n_c     = IW'(1);
                        end
                    end
                    FN_DONE: n_state = i_stat.done_ok ? S_DONE_RD : S_OUT;
                    default: n_state = S_OUT;
                endcase
            end
            S_REG:     n_state = S_OUT;
            S_SCAN:    n_state = S_APP_WR;
            S_APP_WR:  n_state = S_OUT;
            S_DISP:    n_state = S_OUT;
            S_DONE_RD: n_state = S_DONE_WR;
            S_DONE_WR: n_state = S_OUT;
            S_CMPCT: begin
                if (r_c == IW'(SLOTS - 1)) begin
                    if (r_r == IW'(SLOTS - 2)) begin
                        n_state = S_COUNT;
                    end else begin
                        n_r = r_r + 1'b1;
                        n_c = r_r + IW'(2);
                    end
                end else begin
                    n_c = r_c + 1'b1;
                end
            end
            S_COUNT: n_state = S_PEND_CHK;
            S_PEND_CHK: begin
                if (i_pend == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_KEY_RD;
                    n_r     = '0;
                end
            end
            S_KEY_RD: n_state = S_KEY_WR;
            S_KEY_WR: begin
                if (NW'(r_r) == i_pend - 1'b1) begin
                    n_state = S_SORT_START;
                end else begin
                    n_state = S_KEY_RD;
                    n_r     = r_r + 1'b1;
                end
            end
            S_SORT_START: begin
                if (i_pend < NW'(2)) begin
                    n_state = S_AGE;
                end else begin
                    n_state = S_SORT;
                    n_r     = '0;
                    n_c     = IW'(1);
                end
            end
            S_SORT: begin
                if (NW'(r_c) == i_pend - 1'b1) begin
                    if (NW'(r_r) == i_pend - NW'(2)) begin
                        n_state = S_AGE;
                    end else begin
                        n_r = r_r + 1'b1;
                        n_c = r_r + IW'(2);
                    end
                end else begin
                    n_c = r_c + 1'b1;
                end
            end
            S_AGE: begin
                n_state = S_LOAD_RD;
                n_r     = '0;
            end
            S_LOAD_RD: n_state = S_LOAD_WR;
            S_LOAD_WR: begin
                if (NW'(r_r) == size - 1'b1) begin
                    n_state = S_LOAD_END;
                end else begin
                    n_state = S_LOAD_RD;
                    n_r     = r_r + 1'b1;
                end
            end
            S_LOAD_END: n_state = S_OUT;
            S_OUT:      if (!i_out_stall) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd = '{op: OP_NONE, out_valid: 1'b0};
        unique case (r_state)
            S_IDLE:     if (i_valid) o_cmd.op = OP_LATCH;
            S_REG:      o_cmd.op = OP_REG;
            S_SCAN:     o_cmd.op = OP_SCAN;
            S_APP_WR:   if (i_stat.app_found) o_cmd.op = OP_APP_WR;
            S_DISP:     o_cmd.op = OP_DISP;
            S_DONE_RD:  o_cmd.op = OP_DONE_RD;
            S_DONE_WR:  o_cmd.op = OP_DONE_WR;
            S_CMPCT:    o_cmd.op = OP_CMPCT;
            S_COUNT:    o_cmd.op = OP_COUNT;
            S_KEY_RD:   o_cmd.op = OP_KEY_RD;
            S_KEY_WR:   o_cmd.op = OP_KEY_WR;
            S_SORT:     o_cmd.op = OP_SORT;
            S_AGE:      o_cmd.op = OP_AGE;
            S_LOAD_RD:  o_cmd.op = OP_LOAD_RD;
            S_LOAD_WR:  o_cmd.op = OP_LOAD_WR;
            S_LOAD_END: o_cmd.op = OP_LOAD_END;
            S_OUT:      o_cmd.out_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_r        = r_r;
    assign o_c        = r_c;
    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== src/aging_priority_task_dispatcher_core.sv =====
// Aging priority task dispatcher. One beat in gives one result beat out; the
// block takes one beat at a time and holds its input stalled until the result
// has been taken. A process beat that finds the dispatch list spent runs a
// refill on the shared entry store (one read port, registered):
// SLOTS*(SLOTS-1)/2 compaction steps, then a head read for each of P non-empty
// slots, P*(P-1)/2 exchange steps, one ageing step and min(P,DISPATCH) loads.
// Configuration writes are always ready and should only be made while no
// beat is in flight.
module aging_priority_task_dispatcher_core
    import apd_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int RING_DEPTH = RING_DEF,
    parameter int DISPATCH   = DISPATCH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_func,
    input  logic [2:0] i_slot_index,
    input  logic [7:0] i_task_kind,
    input  logic [7:0] i_handler_id,
    input  logic [7:0] i_new_level,
    input  logic [7:0] i_new_event,
    input  logic [7:0] i_new_state,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_status,
    output logic [7:0] o_run_handler,
    output logic [7:0] o_run_kind,
    output logic [7:0] o_run_state,
    output logic [7:0] o_run_event,
    output logic [3:0] o_pending_slots,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int NW = $clog2(SLOTS + 1);

    t_cmd          cmd;
    t_dp_stat      stat;
    logic [IW-1:0] idx_r, idx_c;
    logic [NW-1:0] pend;
    t_entry        run;

    assign o_cfg_ready = 1'b1;

    apd_ctrl #(.SLOTS(SLOTS), .DISPATCH(DISPATCH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_out_stall(i_stall),
        .i_stat     (stat),
        .i_pend     (pend),
        .o_cmd      (cmd),
        .o_r        (idx_r),
        .o_c        (idx_c),
        .o_in_stall (o_stall)
    );

    apd_datapath #(.SLOTS(SLOTS), .RING_DEPTH(RING_DEPTH), .DISPATCH(DISPATCH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid & o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_func         (i_func),
        .i_slot_index   (i_slot_index),
        .i_task_kind    (i_task_kind),
        .i_handler_id   (i_handler_id),
        .i_new_level    (i_new_level),
        .i_new_event    (i_new_event),
        .i_new_state    (i_new_state),
        .i_cmd          (cmd),
        .i_r            (idx_r),
        .i_c            (idx_c),
        .o_stat         (stat),
        .o_pend         (pend),
        .o_status       (o_status),
        .o_run          (run),
        .o_pending_slots(o_pending_slots)
    );

    assign o_valid       = cmd.out_valid;
    assign o_run_handler = run.handler;
    assign o_run_kind    = run.kind;
    assign o_run_state   = run.state;
    assign o_run_event   = run.evt;

endmodule
